// ----- hdl/bitmap_page_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// check that is off while reset is held
`define BPA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also holds across reset
`define BPA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Sizes, result codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int BYTES_W = 28;
    localparam int ADDR_W  = 27;

    // map is kept as 32-bit words, one bit per page
    localparam int WORD_W    = 32;
    localparam int WBIT_W    = $clog2(WORD_W);
    localparam int CNT_W     = $clog2(WORD_W + 1);
    localparam int MAP_WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int RUN_W    = PAGE_W + 1;
    localparam int PB_SHIFT = $clog2(PAGE_BYTES);
    localparam int NEED_W   = BYTES_W + 1 - PB_SHIFT;
    localparam int FSTART_W = ADDR_W - PB_SHIFT;
    localparam int EXT_A    = (NEED_W > FSTART_W) ? NEED_W : FSTART_W;
    localparam int EXT_W    = ((EXT_A > RUN_W) ? EXT_A : RUN_W) + 1;

    localparam int LAST_BITS = PAGE_COUNT % WORD_W;
    // pad bits past the last page read as used
    localparam logic [WORD_W-1:0] LAST_MASK = (LAST_BITS == 0) ? {WORD_W{1'b1}} :
        ({WORD_W{1'b1}} >> (WORD_W - LAST_BITS));

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_ROOM = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic clr_wr;
        logic scan_rd;
        logic scan_ev;
        logic upd_rd;
        logic upd_wr;
        logic post;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic is_free;
        logic skip;
        logic found;
        logic scan_last;
        logic upd_last;
    } stat_t;

endpackage

// ----- hdl/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences map clearing, first-fit scan, run update and result handoff.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  bpa_pkg::stat_t stat,
    output bpa_pkg::cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_EVAL    = 8'b0000_0100,
        S_SCAN_RD = 8'b0000_1000,
        S_SCAN_EV = 8'b0001_0000,
        S_UPD_RD  = 8'b0010_0000,
        S_UPD_WR  = 8'b0100_0000,
        S_POST    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (stat.bad || stat.skip) state_next = S_POST;
                else if (stat.is_free)     state_next = S_UPD_RD;
                else                       state_next = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                cmd.scan_ev = 1'b1;
                if (stat.found)          state_next = S_UPD_RD;
                else if (stat.scan_last) state_next = S_POST;
                else                     state_next = S_SCAN_RD;
            end
            S_UPD_RD: begin
                cmd.upd_rd = 1'b1;
                state_next = S_UPD_WR;
            end
            S_UPD_WR: begin
                cmd.upd_wr = 1'b1;
                state_next = stat.upd_last ? S_POST : S_UPD_RD;
            end
            S_POST: begin
                if (out_free) begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        if (cmd.post)     m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else              m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hdl/bpa_dpath.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Occupancy map memory, word-wise first-fit search and run mask update.
// ----------------------------------------------------------------------------
module bpa_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bpa_pkg::cmd_t                cmd,
    output bpa_pkg::stat_t               stat,
    input  logic                         s_req_type,
    input  logic [bpa_pkg::BYTES_W-1:0]  s_byte_count,
    input  logic [bpa_pkg::ADDR_W-1:0]   s_free_address,
    output logic [bpa_pkg::ADDR_W-1:0]   m_block_address,
    output logic [1:0]                   m_status
);

    localparam int WORD_W = bpa_pkg::WORD_W;
    localparam int WBIT_W = bpa_pkg::WBIT_W;
    localparam int CNT_W  = bpa_pkg::CNT_W;
    localparam int WIDX_W = bpa_pkg::WIDX_W;
    localparam int EXT_W  = bpa_pkg::EXT_W;
    localparam int PAGE_W = bpa_pkg::PAGE_W;
    localparam int RUN_W  = bpa_pkg::RUN_W;
    localparam int NEED_W = bpa_pkg::NEED_W;
    localparam int ADDR_W = bpa_pkg::ADDR_W;
    localparam int BYTES_W = bpa_pkg::BYTES_W;
    localparam int PB_SHIFT = bpa_pkg::PB_SHIFT;

    // lowest set bit position, WORD_W if none
    function automatic logic [CNT_W-1:0] first_one(input logic [WORD_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = CNT_W'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) r = CNT_W'(i);
        end
        return r;
    endfunction

    // number of free bits at the top of the word
    function automatic logic [CNT_W-1:0] lead_free(input logic [WORD_W-1:0] f);
        logic [CNT_W-1:0] r;
        r = CNT_W'(WORD_W);
        for (int i = 0; i < WORD_W; i++) begin
            if (!f[i]) r = CNT_W'(WORD_W - 1 - i);
        end
        return r;
    endfunction

    // bit i set when f[i +: n] is all ones inside the word; built from
    // power-of-two run masks, one per bit of n
    function automatic logic [WORD_W-1:0] runs_of(input logic [WORD_W-1:0] f,
                                                   input logic [CNT_W-1:0]  n);
        logic [WORD_W-1:0] p;
        logic [WORD_W-1:0] acc;
        logic              have;
        p    = f;
        acc  = '0;
        have = 1'b0;
        for (int k = 0; k < CNT_W; k++) begin
            if (n[k]) begin
                acc  = have ? (p & (acc >> (1 << k))) : p;
                have = 1'b1;
            end
            p = p & (p >> (1 << k));
        end
        return acc;
    endfunction

    function automatic logic [WIDX_W-1:0] word_of(input logic [EXT_W-1:0] page);
        logic [EXT_W-1:0] t;
        t = page >> WBIT_W;
        return t[WIDX_W-1:0];
    endfunction

    logic [WORD_W-1:0]  map_mem [bpa_pkg::MAP_WORDS];

    logic               req_type_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               bad_reg;
    logic [WIDX_W-1:0]  word_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [PAGE_W-1:0]  start_reg;
    logic [PAGE_W-1:0]  lo_reg;
    logic [PAGE_W-1:0]  hi_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [1:0]         res_status_reg;
    logic [ADDR_W-1:0]  m_block_address_reg;
    logic [1:0]         m_status_reg;

    logic [BYTES_W:0]   bsum;
    logic [EXT_W-1:0]   need_ext, fstart_ext, fend_ext, fhi_ext, fhi_m1_ext;
    logic               too_big, beyond;
    logic               word_last;

    logic [WORD_W-1:0]  free_bits, hit;
    logic [CNT_W-1:0]   tz, lz, in_pos;
    logic [EXT_W-1:0]   base_ext, carry_sum, carry_start, found_start, found_end;
    logic [EXT_W-1:0]   new_start;
    logic               carry_hit, in_hit, found, all_free;
    logic [EXT_W+PB_SHIFT-1:0] byte_addr;

    logic [EXT_W-1:0]   lo_ext, hi_ext;
    logic [WBIT_W-1:0]  lo_bit;
    logic               hi_here;
    logic [WORD_W-1:0]  upd_mask, wr_data;

    // request decode
    assign bsum       = {1'b0, s_byte_count} + (BYTES_W + 1)'(bpa_pkg::PAGE_BYTES - 1);
    assign need_ext   = EXT_W'(need_reg);
    assign fstart_ext = EXT_W'(addr_reg[ADDR_W-1:PB_SHIFT]);
    assign fend_ext   = fstart_ext + need_ext;
    assign fhi_ext    = (fend_ext > EXT_W'(bpa_pkg::PAGE_COUNT)) ?
                        EXT_W'(bpa_pkg::PAGE_COUNT) : fend_ext;
    assign fhi_m1_ext = fhi_ext - EXT_W'(1);
    assign too_big    = need_ext > EXT_W'(bpa_pkg::PAGE_COUNT);
    assign beyond     = fstart_ext >= EXT_W'(bpa_pkg::PAGE_COUNT);
    assign word_last  = (word_reg == WIDX_W'(bpa_pkg::MAP_WORDS - 1));

    // first-fit over one map word
    assign free_bits   = ~rd_data_reg & (word_last ? bpa_pkg::LAST_MASK : {WORD_W{1'b1}});
    assign tz          = first_one(~free_bits);
    assign lz          = lead_free(free_bits);
    assign all_free    = (tz == CNT_W'(WORD_W));
    assign base_ext    = EXT_W'(word_reg) << WBIT_W;
    assign carry_sum   = EXT_W'(run_reg) + EXT_W'(tz);
    assign carry_hit   = carry_sum >= need_ext;
    assign carry_start = (run_reg == '0) ? base_ext : EXT_W'(start_reg);
    assign hit         = runs_of(free_bits, need_ext[CNT_W-1:0]);
    assign in_hit      = (need_ext <= EXT_W'(WORD_W)) && (|hit);
    assign in_pos      = first_one(hit);
    assign found       = carry_hit || in_hit;
    assign found_start = carry_hit ? carry_start : base_ext + EXT_W'(in_pos);
    assign found_end   = found_start + need_ext - EXT_W'(1);
    assign new_start   = base_ext + EXT_W'(WORD_W) - EXT_W'(lz);
    assign byte_addr   = {found_start, {PB_SHIFT{1'b0}}};

    // set or clear mask for the run inside the current word
    assign lo_ext   = EXT_W'(lo_reg);
    assign hi_ext   = EXT_W'(hi_reg);
    assign lo_bit   = (word_reg == word_of(lo_ext)) ? lo_ext[WBIT_W-1:0] : '0;
    assign hi_here  = (word_reg == word_of(hi_ext));
    assign upd_mask = ({WORD_W{1'b1}} << lo_bit) &
                      (hi_here ? ({WORD_W{1'b1}} >> (WBIT_W'(WORD_W - 1) - hi_ext[WBIT_W-1:0]))
                               : {WORD_W{1'b1}});
    assign wr_data  = (req_type_reg == bpa_pkg::REQ_FREE) ? (rd_data_reg & ~upd_mask)
                                                          : (rd_data_reg | upd_mask);

    always_comb begin
        stat           = '0;
        stat.clr_last  = word_last;
        stat.bad       = bad_reg;
        stat.is_free   = (req_type_reg == bpa_pkg::REQ_FREE);
        stat.skip      = stat.is_free ? beyond : too_big;
        stat.found     = found;
        stat.scan_last = word_last;
        stat.upd_last  = hi_here;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr)      map_mem[word_reg] <= '0;
        else if (cmd.upd_wr) map_mem[word_reg] <= wr_data;
        if (cmd.scan_rd || cmd.upd_rd) rd_data_reg <= map_mem[word_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else if (cmd.clr_wr) begin
            word_reg <= word_last ? '0 : word_reg + WIDX_W'(1);
        end else if (cmd.eval) begin
            word_reg <= stat.is_free ? word_of(fstart_ext) : '0;
        end else if (cmd.scan_ev) begin
            word_reg <= found ? word_of(found_start) : word_reg + WIDX_W'(1);
        end else if (cmd.upd_wr) begin
            word_reg <= word_reg + WIDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= s_req_type;
            need_reg     <= bsum[BYTES_W:PB_SHIFT];
            addr_reg     <= s_free_address;
            bad_reg      <= (s_byte_count == '0) ||
                            (s_req_type == bpa_pkg::REQ_FREE && s_free_address == '0);
        end
        if (cmd.eval) begin
            run_reg      <= '0;
            lo_reg       <= fstart_ext[PAGE_W-1:0];
            hi_reg       <= fhi_m1_ext[PAGE_W-1:0];
            res_addr_reg <= '0;
            if (bad_reg)                        res_status_reg <= bpa_pkg::STATUS_INVALID;
            else if (!stat.is_free && too_big)  res_status_reg <= bpa_pkg::STATUS_NO_ROOM;
            else                                res_status_reg <= bpa_pkg::STATUS_OK;
        end
        if (cmd.scan_ev) begin
            if (found) begin
                lo_reg         <= found_start[PAGE_W-1:0];
                hi_reg         <= found_end[PAGE_W-1:0];
                res_addr_reg   <= byte_addr[ADDR_W-1:0];
                res_status_reg <= bpa_pkg::STATUS_OK;
            end else begin
                run_reg        <= all_free ? carry_sum[RUN_W-1:0] : RUN_W'(lz);
                start_reg      <= all_free ? carry_start[PAGE_W-1:0] : new_start[PAGE_W-1:0];
                if (word_last) res_status_reg <= bpa_pkg::STATUS_NO_ROOM;
            end
        end
        if (cmd.post) begin
            m_block_address_reg <= res_addr_reg;
            m_status_reg        <= res_status_reg;
        end
    end

    assign m_block_address = m_block_address_reg;
    assign m_status        = m_status_reg;

endmodule

// ----- hdl/bitmap_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit page allocator over a one-bit-per-page occupancy map.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per handshake. s_req_type selects allocate
// (s_byte_count rounded up to pages) or free (pages from s_free_address).
// Result channel m_*: exactly one result per request, m_block_address and
// m_status (ok, no room, invalid).
// One request is in work at a time; s_ready is high only while idle.
// The map sits in a 1024 x 32 memory with one port; every visited word is
// read, then evaluated or written back.
// Allocate: load, evaluate, scan words up to the fitting run, mark the words
// of the run, then post. Free: load, evaluate, clear each word covered, post.
// Rejected requests: load, evaluate, post.
// After reset the map is cleared one word per cycle with s_ready low. A
// stalled result stays in the output register; the block takes the next
// request meanwhile and holds its result until the output register empties.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [bpa_pkg::BYTES_W-1:0]  s_byte_count,
    input  logic [bpa_pkg::ADDR_W-1:0]   s_free_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bpa_pkg::ADDR_W-1:0]   m_block_address,
    output logic [1:0]                   m_status
);

    bpa_pkg::cmd_t  cmd;
    bpa_pkg::stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpa_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_req_type      (s_req_type),
        .s_byte_count    (s_byte_count),
        .s_free_address  (s_free_address),
        .m_block_address (m_block_address),
        .m_status        (m_status)
    );

endmodule

// ----- hdl/bpa_checker.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator port checker
// Checks result coding and request sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_unit_macros.svh"

module bpa_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bpa_pkg::ADDR_W-1:0]  m_block_address,
    input logic [1:0]                  m_status
);

    `BPA_ASSERT(a_status_code, aclk, aresetn, m_valid |-> (m_status == bpa_pkg::STATUS_OK || m_status == bpa_pkg::STATUS_NO_ROOM || m_status == bpa_pkg::STATUS_INVALID), "bad status code")

    `BPA_ASSERT(a_fail_addr_zero, aclk, aresetn, (m_valid && m_status != bpa_pkg::STATUS_OK) |-> (m_block_address == '0), "nonzero address on failed request")

    `BPA_ASSERT(a_result_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_block_address) && $stable(m_status)), "stalled result changed")

    `BPA_ASSERT(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "request taken while busy")

    `BPA_ASSERT_RST(a_reset_busy, aclk, !aresetn |=> !s_ready, "ready during map clear")

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_block_address (m_block_address),
    .m_status        (m_status)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// A table of allocate and free requests runs first, then a random mix of
// well-formed allocate/free pairs with some malformed noise. A shadow page
// map predicts model and random results, table rows give theirs; all are checked in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BYTES_W         = bpa_pkg::BYTES_W;
    localparam int          ADDR_W          = bpa_pkg::ADDR_W;
    localparam int          PAGES           = bpa_pkg::PAGE_COUNT;
    localparam int          RANDOM_REQUESTS = 266;
    localparam int          IDLE_PCT        = 26;
    localparam int          CALM_FIRST      = 120;
    localparam int          CALM_LAST       = 180;
    localparam int          MAX_LIVE        = 48;
    localparam int          WATCHDOG_CYCLES = 20000;
    localparam int          DRAIN_CYCLES    = 64;
    localparam int          RESET_CYCLES    = 8;
    localparam int          PB              = bpa_pkg::PAGE_BYTES;
    localparam int unsigned MAP_BYTES       = PAGES * PB;
    localparam int unsigned BYTES_TOP       = (1 << BYTES_W) - 1;

    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [ADDR_W-1:0]  ADDR_MAX  = '1;

    // where a table row takes its expected result from
    localparam logic FROM_TABLE = 1'b1;
    localparam logic FROM_MODEL = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        bpa_pkg::status_t  status;
    } page_result_t;

    typedef struct packed {
        logic               req_type;
        logic [BYTES_W-1:0] byte_count;
        logic [ADDR_W-1:0]  free_address;
        logic               source;
        logic [ADDR_W-1:0]  block_address;
        bpa_pkg::status_t   status;
    } page_request_row_t;

    typedef struct {
        int unsigned first_page;
        int unsigned pages;
    } live_block_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_req_type     = bpa_pkg::REQ_ALLOC;
    logic [BYTES_W-1:0] s_byte_count   = '0;
    logic [ADDR_W-1:0]  s_free_address = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [ADDR_W-1:0]  m_block_address;
    logic [1:0]         m_status;

    bit                shadow_page_map [PAGES];
    page_result_t      pending_results [$];
    live_block_t       live_blocks [$];
    page_request_row_t directed_rows [24];
    int                idle_pct     = IDLE_PCT;
    int                error_count  = 0;
    int                quiet_cycles = 0;

    bitmap_page_allocator_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_byte_count    (s_byte_count),
        .s_free_address  (s_free_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_block_address (m_block_address),
        .m_status        (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic page_request_row_t mk_row(input logic req_type,
            input longint byte_count, input longint free_address, input logic source,
            input longint block_address, input bpa_pkg::status_t status);
        page_request_row_t row;
        row.req_type      = req_type;
        row.byte_count    = BYTES_W'(byte_count);
        row.free_address  = ADDR_W'(free_address);
        row.source        = source;
        row.block_address = ADDR_W'(block_address);
        row.status        = status;
        return row;
    endfunction

    // first-fit allocate or free against the shadow map
    function automatic page_result_t apply_page_request(input logic req_type,
            input logic [BYTES_W-1:0] byte_count, input logic [ADDR_W-1:0] free_address);
        page_result_t res;
        longint       need;
        longint       run;
        longint       first;
        res.block_address = '0;
        res.status        = bpa_pkg::STATUS_INVALID;
        if (byte_count == 0)
            return res;
        need = (longint'(byte_count) + PB - 1) / PB;
        if (req_type == bpa_pkg::REQ_ALLOC) begin
            res.status = bpa_pkg::STATUS_NO_ROOM;
            if (need > PAGES)
                return res;
            run   = 0;
            first = 0;
            for (int p = 0; p < PAGES; p++) begin
                if (shadow_page_map[p]) begin
                    run = 0;
                end else begin
                    if (run == 0)
                        first = p;
                    run++;
                    if (run == need) begin
                        for (longint q = first; q < first + need; q++)
                            shadow_page_map[q] = 1'b1;
                        res.block_address = ADDR_W'(first * PB);
                        res.status        = bpa_pkg::STATUS_OK;
                        return res;
                    end
                end
            end
            return res;
        end
        if (free_address == 0)
            return res;
        first = longint'(free_address) / PB;
        for (longint p = first; p < first + need && p < PAGES; p++)
            shadow_page_map[p] = 1'b0;
        res.status = bpa_pkg::STATUS_OK;
        return res;
    endfunction

    task automatic issue_request(input logic req_type, input logic [BYTES_W-1:0] byte_count,
            input logic [ADDR_W-1:0] free_address, input logic source,
            input page_result_t table_result, output page_result_t predicted);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req_type;
        s_byte_count   <= byte_count;
        s_free_address <= free_address;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        predicted = apply_page_request(req_type, byte_count, free_address);
        pending_results.push_back(source == FROM_TABLE ? table_result : predicted);
    endtask

    initial begin
        page_result_t       got;
        live_block_t        blk;
        int unsigned        pick;
        int unsigned        pages;
        int unsigned        dice;
        int unsigned        roll;
        logic               req_type;
        logic [BYTES_W-1:0] byte_count;
        logic [ADDR_W-1:0]  free_address;

        directed_rows = '{
            mk_row(bpa_pkg::REQ_ALLOC, 0, 0, FROM_TABLE, 0, bpa_pkg::STATUS_INVALID),
            mk_row(bpa_pkg::REQ_FREE, 0, PB, FROM_TABLE, 0, bpa_pkg::STATUS_INVALID),
            mk_row(bpa_pkg::REQ_FREE, PB, 0, FROM_TABLE, 0, bpa_pkg::STATUS_INVALID),
            mk_row(bpa_pkg::REQ_ALLOC, BYTES_MAX, ADDR_MAX, FROM_TABLE, 0,
                   bpa_pkg::STATUS_NO_ROOM),
            // one byte past the whole map rounds to one page too many
            mk_row(bpa_pkg::REQ_ALLOC, MAP_BYTES + 1, 0, FROM_TABLE, 0,
                   bpa_pkg::STATUS_NO_ROOM),
            mk_row(bpa_pkg::REQ_ALLOC, MAP_BYTES, 0, FROM_TABLE, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, 1, 0, FROM_TABLE, 0, bpa_pkg::STATUS_NO_ROOM),
            mk_row(bpa_pkg::REQ_FREE, 1, ADDR_MAX, FROM_TABLE, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, PB, 0, FROM_TABLE, MAP_BYTES - PB,
                   bpa_pkg::STATUS_OK),
            // page 0 stays held for good from here on
            mk_row(bpa_pkg::REQ_FREE, BYTES_MAX, PB, FROM_TABLE, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_FREE, PB, PB, FROM_TABLE, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, 1, 0, FROM_TABLE, PB, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, PB + 1, 0, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, 3 * PB, ADDR_MAX, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_FREE, PB, 2 * PB + 5, FROM_TABLE, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, PB, 0, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, 2 * PB, 0, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_FREE, 3 * PB - 1, 4 * PB, FROM_TABLE, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, 4 * PB, 0, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, 3 * PB, 0, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, MAP_BYTES - 1, PB, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_FREE, BYTES_MAX, MAP_BYTES - PB, FROM_TABLE, 0,
                   bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_ALLOC, 1, ADDR_MAX, FROM_MODEL, 0, bpa_pkg::STATUS_OK),
            mk_row(bpa_pkg::REQ_FREE, MAP_BYTES, PB, FROM_TABLE, 0, bpa_pkg::STATUS_OK)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].req_type, directed_rows[i].byte_count,
                          directed_rows[i].free_address, directed_rows[i].source,
                          page_result_t'({directed_rows[i].block_address,
                                          directed_rows[i].status}), got);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            idle_pct     = (n >= CALM_FIRST && n < CALM_LAST) ? 0 : IDLE_PCT;
            dice         = $urandom_range(99);
            free_address = ADDR_W'($urandom);
            if (live_blocks.size() > MAX_LIVE ||
                    (dice >= 45 && dice < 85 && live_blocks.size() != 0)) begin
                // give back a block handed out earlier, addressed anywhere in its first page
                pick = $urandom_range(live_blocks.size() - 1);
                blk  = live_blocks[pick];
                live_blocks.delete(pick);
                req_type     = bpa_pkg::REQ_FREE;
                free_address = ADDR_W'(blk.first_page * PB + $urandom_range(PB - 1));
                byte_count   = BYTES_W'($urandom_range((blk.pages - 1) * PB + 1,
                                                       blk.pages * PB));
            end else if (dice < 85) begin
                req_type = bpa_pkg::REQ_ALLOC;
                roll     = $urandom_range(99);
                if (roll < 2) begin
                    byte_count = BYTES_W'($urandom_range(MAP_BYTES + 1, BYTES_TOP));
                end else begin
                    if (roll < 6)
                        pages = $urandom_range(PAGES / 8, PAGES);
                    else if (roll < 20)
                        pages = $urandom_range(9, 256);
                    else
                        pages = $urandom_range(1, 8);
                    byte_count = BYTES_W'($urandom_range((pages - 1) * PB + 1, pages * PB));
                end
            end else begin
                // malformed or arbitrary requests
                req_type = ($urandom_range(3) == 0) ? bpa_pkg::REQ_ALLOC : bpa_pkg::REQ_FREE;
                roll     = $urandom_range(99);
                if (roll < 25) begin
                    byte_count = '0;
                end else if (roll < 50) begin
                    req_type     = bpa_pkg::REQ_FREE;
                    free_address = '0;
                    byte_count   = BYTES_W'($urandom_range(1, 16 * PB));
                end else if (roll < 85) begin
                    byte_count = BYTES_W'($urandom_range(1, 16 * PB));
                end else begin
                    byte_count = BYTES_W'($urandom);
                end
            end
            issue_request(req_type, byte_count, free_address, FROM_MODEL, '0, got);
            if (req_type == bpa_pkg::REQ_ALLOC && got.status == bpa_pkg::STATUS_OK) begin
                blk.first_page = got.block_address / PB;
                blk.pages      = (byte_count + PB - 1) / PB;
                live_blocks.push_back(blk);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result checking, result-side backpressure and the watchdog
    always @(posedge aclk) begin
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("m_status: no request outstanding, got status %0d address 'h%0h",
                       m_status, m_block_address);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_block_address !== want.block_address) begin
                    $error("m_block_address: expected 'h%0h, actual 'h%0h",
                           want.block_address, m_block_address);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, actual %0d", want.status, m_status);
                    error_count++;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_ready <= ($urandom_range(99) >= idle_pct);
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
